// ===== hw/rtl/tbe_pkg.sv =====
package tbe_pkg;

  // Request kinds carried in the slave-side tuser bit.
  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_START = 1'b1
  } tbe_op_e;

endpackage

// ===== hw/rtl/triangle_bbox_edge_rasterizer_unit.sv =====
// Channel   Direction  tdata (low bit up)                           tuser        tlast
// s_axis    in         a_x, a_y, b_x, b_y, c_x, c_y, color, pad      opcode       -
// m_axis    out        pixel_x, pixel_y, pixel_color, pad            write_pixel  last_position
//
// A start or step is accepted in any cycle in which the single output register
// is empty or is being drained.
// A step during a walk loads the output register at its accepting edge, so its result
// is offered in the next cycle; the box walk, edge test and output register set this.
// Reset clears the walk and the output valid; the walk restarts only with a start.
// A stall on m_axis holds the result and back-pressures s_axis through tready.
module triangle_bbox_edge_rasterizer_unit
  import tbe_pkg::*;
#(
  parameter int COORD_WIDTH = 12,
  parameter int COLOR_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // a_x, a_y, b_x, b_y, c_x, c_y, fill_color, zero pad
  input  logic [((6*COORD_WIDTH+COLOR_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // opcode
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*(COORD_WIDTH-1)+COLOR_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // write_pixel
  output logic                  m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  localparam int CW        = COORD_WIDTH;
  localparam int OUT_W     = 2 * (CW - 1) + COLOR_WIDTH;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;

  logic signed [CW-1:0]   in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic [COLOR_WIDTH-1:0] in_color;

  logic [CW-2:0]          su_left, su_top;
  logic signed [CW-1:0]   su_right, su_bottom;
  logic                   su_active;
  logic signed [CW:0]     su_e1x, su_e1y, su_e2x, su_e2y;
  logic signed [2*CW+2:0] su_det;

  logic                   walk_active_q, walk_active_d;
  logic [CW-2:0]          box_left_q, cur_x_q, cur_y_q;
  logic signed [CW-1:0]   box_right_q, box_bottom_q, vert_cx_q, vert_cy_q;
  logic signed [CW:0]     e1x_q, e1y_q, e2x_q, e2y_q;
  logic signed [2*CW+2:0] det_q;
  logic [COLOR_WIDTH-1:0] color_q;

  logic                   out_valid_q, out_valid_d;
  logic [CW-2:0]          out_x_q, out_y_q;
  logic [COLOR_WIDTH-1:0] out_color_q;
  logic                   out_write_q, out_last_q;

  logic                   s_fire, start_fire, step_fire;
  logic                   at_right, at_bottom, is_last, covered;

  assign in_ax    = s_axis_tdata_i[0*CW +: CW];
  assign in_ay    = s_axis_tdata_i[1*CW +: CW];
  assign in_bx    = s_axis_tdata_i[2*CW +: CW];
  assign in_by    = s_axis_tdata_i[3*CW +: CW];
  assign in_cx    = s_axis_tdata_i[4*CW +: CW];
  assign in_cy    = s_axis_tdata_i[5*CW +: CW];
  assign in_color = s_axis_tdata_i[6*CW +: COLOR_WIDTH];

  tbe_setup #(.CW(CW)) u_setup (
    .ax_i     (in_ax),
    .ay_i     (in_ay),
    .bx_i     (in_bx),
    .by_i     (in_by),
    .cx_i     (in_cx),
    .cy_i     (in_cy),
    .left_o   (su_left),
    .top_o    (su_top),
    .right_o  (su_right),
    .bottom_o (su_bottom),
    .active_o (su_active),
    .e1x_o    (su_e1x),
    .e1y_o    (su_e1y),
    .e2x_o    (su_e2x),
    .e2y_o    (su_e2y),
    .det_o    (su_det)
  );

  tbe_cover #(.CW(CW)) u_cover (
    .px_i     (cur_x_q),
    .py_i     (cur_y_q),
    .cx_i     (vert_cx_q),
    .cy_i     (vert_cy_q),
    .e1x_i    (e1x_q),
    .e1y_i    (e1y_q),
    .e2x_i    (e2x_q),
    .e2y_i    (e2y_q),
    .det_i    (det_q),
    .inside_o (covered)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign start_fire      = s_fire && (tbe_op_e'(s_axis_tuser_i) == OP_START);
  assign step_fire       = s_fire && (tbe_op_e'(s_axis_tuser_i) == OP_STEP) && walk_active_q;

  assign at_right  = $signed({1'b0, cur_x_q}) >= box_right_q;
  assign at_bottom = $signed({1'b0, cur_y_q}) >= box_bottom_q;
  assign is_last   = at_right && at_bottom;

  always_comb begin
    walk_active_d = walk_active_q;
    if (start_fire) begin
      walk_active_d = su_active;
    end else if (step_fire && is_last) begin
      walk_active_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      walk_active_q <= walk_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_fire) begin
      box_left_q   <= su_left;
      box_right_q  <= su_right;
      box_bottom_q <= su_bottom;
      cur_x_q      <= su_left;
      cur_y_q      <= su_top;
      vert_cx_q    <= in_cx;
      vert_cy_q    <= in_cy;
      e1x_q        <= su_e1x;
      e1y_q        <= su_e1y;
      e2x_q        <= su_e2x;
      e2y_q        <= su_e2y;
      det_q        <= su_det;
      color_q      <= in_color;
    end else if (step_fire && !is_last) begin
      if (at_right) begin
        cur_x_q <= box_left_q;
        cur_y_q <= cur_y_q + 1'b1;
      end else begin
        cur_x_q <= cur_x_q + 1'b1;
      end
    end
    if (step_fire) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_color_q <= color_q;
      out_write_q <= covered;
      out_last_q  <= is_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = (OUT_BYTES*8)'({out_color_q, out_y_q, out_x_q});
  assign m_axis_tuser_o  = out_write_q;
  assign m_axis_tlast_o  = out_last_q;

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && is_last && !start_fire) |=> !walk_active_q)
    else $error("walk still active after the final box position");

  a_valid_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_fire))
    else $error("result appeared without an accepted step");

  a_cursor_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_active_q |-> ($signed({1'b0, cur_x_q}) <= box_right_q) &&
                      ($signed({1'b0, cur_y_q}) <= box_bottom_q) &&
                      (cur_x_q >= box_left_q))
    else $error("cursor left the bounding box");

endmodule

// ===== hw/rtl/tbe_setup.sv =====
module tbe_setup #(
  parameter int CW = 12
) (
  input  logic signed [CW-1:0]   ax_i,
  input  logic signed [CW-1:0]   ay_i,
  input  logic signed [CW-1:0]   bx_i,
  input  logic signed [CW-1:0]   by_i,
  input  logic signed [CW-1:0]   cx_i,
  input  logic signed [CW-1:0]   cy_i,
  output logic        [CW-2:0]   left_o,
  output logic        [CW-2:0]   top_o,
  output logic signed [CW-1:0]   right_o,
  output logic signed [CW-1:0]   bottom_o,
  output logic                   active_o,
  output logic signed [CW:0]     e1x_o,
  output logic signed [CW:0]     e1y_o,
  output logic signed [CW:0]     e2x_o,
  output logic signed [CW:0]     e2y_o,
  output logic signed [2*CW+2:0] det_o
);

  logic signed [CW-1:0]   min_x, max_x, min_y, max_y;
  logic signed [CW:0]     ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
  logic signed [CW:0]     acx, bcx;
  logic signed [2*CW+1:0] prod_0, prod_1;

  always_comb begin
    min_x = ax_i;
    if (bx_i < min_x) min_x = bx_i;
    if (cx_i < min_x) min_x = cx_i;
    max_x = ax_i;
    if (bx_i > max_x) max_x = bx_i;
    if (cx_i > max_x) max_x = cx_i;
    min_y = ay_i;
    if (by_i < min_y) min_y = by_i;
    if (cy_i < min_y) min_y = cy_i;
    max_y = ay_i;
    if (by_i > max_y) max_y = by_i;
    if (cy_i > max_y) max_y = cy_i;
  end

  // The low corner is raised to zero, so it fits one bit narrower.
  assign left_o   = min_x[CW-1] ? '0 : min_x[CW-2:0];
  assign top_o    = min_y[CW-1] ? '0 : min_y[CW-2:0];
  assign right_o  = max_x;
  assign bottom_o = max_y;
  assign active_o = ($signed({1'b0, left_o}) <= max_x) && ($signed({1'b0, top_o}) <= max_y);

  assign ax_e = {ax_i[CW-1], ax_i};
  assign ay_e = {ay_i[CW-1], ay_i};
  assign bx_e = {bx_i[CW-1], bx_i};
  assign by_e = {by_i[CW-1], by_i};
  assign cx_e = {cx_i[CW-1], cx_i};
  assign cy_e = {cy_i[CW-1], cy_i};

  assign e1x_o = by_e - cy_e;
  assign e1y_o = cx_e - bx_e;
  assign e2x_o = cy_e - ay_e;
  assign e2y_o = ax_e - cx_e;
  assign acx   = ax_e - cx_e;
  assign bcx   = bx_e - cx_e;

  assign prod_0 = acx * e1x_o;
  assign prod_1 = bcx * (ay_e - cy_e);
  assign det_o  = (2*CW+3)'(prod_0) - (2*CW+3)'(prod_1);

endmodule

// ===== hw/rtl/tbe_cover.sv =====
module tbe_cover #(
  parameter int CW = 12
) (
  input  logic        [CW-2:0]   px_i,
  input  logic        [CW-2:0]   py_i,
  input  logic signed [CW-1:0]   cx_i,
  input  logic signed [CW-1:0]   cy_i,
  input  logic signed [CW:0]     e1x_i,
  input  logic signed [CW:0]     e1y_i,
  input  logic signed [CW:0]     e2x_i,
  input  logic signed [CW:0]     e2y_i,
  input  logic signed [2*CW+2:0] det_i,
  output logic                   inside_o
);

  localparam int PW = 2 * CW + 5;

  logic signed [CW:0]     dx, dy;
  logic signed [2*CW+1:0] m1x, m1y, m2x, m2y;
  logic signed [PW-1:0]   w1, w2, w3, det_w;
  logic                   ok1, ok2, ok3;

  assign dx = $signed({2'b00, px_i}) - $signed({cx_i[CW-1], cx_i});
  assign dy = $signed({2'b00, py_i}) - $signed({cy_i[CW-1], cy_i});

  assign m1x = e1x_i * dx;
  assign m1y = e1y_i * dy;
  assign m2x = e2x_i * dx;
  assign m2y = e2y_i * dy;

  assign w1    = PW'(m1x) + PW'(m1y);
  assign w2    = PW'(m2x) + PW'(m2y);
  assign det_w = PW'(det_i);
  assign w3    = det_w - w1 - w2;

  // Zero always passes; otherwise the sign must match the sign of det.
  assign ok1 = (w1 == '0) || (w1[PW-1] == det_w[PW-1]);
  assign ok2 = (w2 == '0) || (w2[PW-1] == det_w[PW-1]);
  assign ok3 = (w3 == '0) || (w3[PW-1] == det_w[PW-1]);

  assign inside_o = ok1 && ok2 && ok3;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tbe_pkg::*;

  localparam int IN_W = 88;
  localparam int OUT_W = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 140;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [15:0] color;
    logic        wr;
    logic        last;
  } pixel_t;

  typedef struct packed {
    tbe_op_e            op;
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [11:0] bx;
    logic signed [11:0] by;
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [15:0]        color;
    int                 reps;
    logic               typed;
    pixel_t             want;
  } stim_row_t;

  localparam pixel_t NO_PIXEL = '0;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_valid = 1'b0;
  logic [IN_W-1:0] s_data = '0;
  logic            s_user = OP_STEP;
  logic            m_ready = 1'b0;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic            m_axis_tuser_o;
  logic            m_axis_tlast_o;

  triangle_bbox_edge_rasterizer_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the triangle, the box and the walk cursor.
  int          tri_x[3];
  int          tri_y[3];
  logic [15:0] paint;
  int          box_l, box_r, box_b;
  int          cur_x, cur_y;
  bit          walking;

  pixel_t pending_pixels[$];
  int     drawn_or_started = 0;
  int     tx_gap_pct = 0;
  int     rx_stall_pct = 0;
  bit     failed = 1'b0;
  int     quiet_cycles = 0;
  pixel_t got_px, want_px;

  function automatic bit sign_agrees(longint v, longint det);
    return (v == 0) || ((v >= 0) == (det >= 0));
  endfunction

  function automatic bit on_triangle(int px, int py);
    longint det, w1, w2, w3;
    det = longint'(tri_x[0] - tri_x[2]) * (tri_y[1] - tri_y[2])
        - longint'(tri_x[1] - tri_x[2]) * (tri_y[0] - tri_y[2]);
    w1 = longint'(tri_y[1] - tri_y[2]) * (px - tri_x[2])
       + longint'(tri_x[2] - tri_x[1]) * (py - tri_y[2]);
    w2 = longint'(tri_y[2] - tri_y[0]) * (px - tri_x[2])
       + longint'(tri_x[0] - tri_x[2]) * (py - tri_y[2]);
    w3 = det - w1 - w2;
    return sign_agrees(w1, det) && sign_agrees(w2, det) && sign_agrees(w3, det);
  endfunction

  function automatic void raster_next(input tbe_op_e op, input logic [IN_W-1:0] data,
                                      output bit made, output pixel_t px);
    int top;
    made = 1'b0;
    px = NO_PIXEL;
    if (op == OP_START) begin
      for (int i = 0; i < 3; i++) begin
        tri_x[i] = $signed(data[24*i +: 12]);
        tri_y[i] = $signed(data[24*i+12 +: 12]);
      end
      paint = data[72 +: 16];
      box_l = tri_x[0];
      box_r = tri_x[0];
      top = tri_y[0];
      box_b = tri_y[0];
      for (int i = 1; i < 3; i++) begin
        if (tri_x[i] < box_l) box_l = tri_x[i];
        if (tri_x[i] > box_r) box_r = tri_x[i];
        if (tri_y[i] < top) top = tri_y[i];
        if (tri_y[i] > box_b) box_b = tri_y[i];
      end
      if (box_l < 0) box_l = 0;
      if (top < 0) top = 0;
      cur_x = box_l;
      cur_y = top;
      walking = (box_l <= box_r) && (top <= box_b);
    end else if (walking) begin
      made = 1'b1;
      px.x = cur_x[10:0];
      px.y = cur_y[10:0];
      px.color = paint;
      px.wr = on_triangle(cur_x, cur_y);
      px.last = (cur_x >= box_r) && (cur_y >= box_b);
      if (px.last) begin
        walking = 1'b0;
      end else if (cur_x >= box_r) begin
        cur_x = box_l;
        cur_y = cur_y + 1;
      end else begin
        cur_x = cur_x + 1;
      end
    end
  endfunction

  function automatic logic [IN_W-1:0] pack_request(int ax, int ay, int bx, int by,
                                                    int cx, int cy, logic [15:0] color);
    return {color, cy[11:0], cx[11:0], by[11:0], bx[11:0], ay[11:0], ax[11:0]};
  endfunction

  function automatic logic [IN_W-1:0] junk_data();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[IN_W-1:0];
  endfunction

  task automatic send(input tbe_op_e op, input logic [IN_W-1:0] data,
                      input bit typed, input pixel_t want);
    int gap;
    bit made;
    pixel_t px;
    gap = 0;
    if (tx_gap_pct > 0) begin
      while ($urandom_range(1, 100) <= tx_gap_pct) gap++;
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= data;
    s_user <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    raster_next(op, data, made, px);
    if (made) begin
      pending_pixels.push_back(typed ? want : px);
      drawn_or_started++;
    end else if (op == OP_START) begin
      drawn_or_started++;
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  task automatic send_step();
    send(OP_STEP, junk_data(), 1'b0, NO_PIXEL);
  endtask

  task automatic random_burst(int n);
    int target, pick, size, ox, oy, limit, k;
    int v[6];
    target = drawn_or_started + n;
    while (drawn_or_started < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        size = $urandom_range(1, 7);
        ox = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) - 8
                                         : int'($urandom_range(0, 2040));
        oy = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) - 8
                                         : int'($urandom_range(0, 2040));
        for (int i = 0; i < 3; i++) begin
          v[2*i] = ox + $urandom_range(0, size);
          v[2*i+1] = oy + $urandom_range(0, size);
        end
        send(OP_START, pack_request(v[0], v[1], v[2], v[3], v[4], v[5], 16'($urandom)),
             1'b0, NO_PIXEL);
        limit = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : 1000;
        k = 0;
        while (walking && k < limit) begin
          send_step();
          k++;
        end
        if ($urandom_range(0, 3) == 0) send_step();
      end else if (pick < 85) begin
        send(OP_START, junk_data(), 1'b0, NO_PIXEL);
        repeat ($urandom_range(0, 30)) send_step();
      end else begin
        repeat ($urandom_range(1, 3)) send_step();
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got_px.x = m_axis_tdata_o[10:0];
      got_px.y = m_axis_tdata_o[21:11];
      got_px.color = m_axis_tdata_o[37:22];
      got_px.wr = m_axis_tuser_o;
      got_px.last = m_axis_tlast_o;
      if (pending_pixels.size() == 0) begin
        $error("pixel request with none expected: x %0d y %0d", got_px.x, got_px.y);
        failed = 1'b1;
      end else begin
        want_px = pending_pixels.pop_front();
        check_field("pixel_x", want_px.x, got_px.x);
        check_field("pixel_y", want_px.y, got_px.y);
        check_field("pixel_color", want_px.color, got_px.color);
        check_field("write_pixel", want_px.wr, got_px.wr);
        check_field("last_position", want_px.last, got_px.last);
      end
    end
    m_ready <= (rx_stall_pct == 0) || ($urandom_range(1, 100) > rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  stim_row_t dir_rows[22] = '{
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 1'b0, NO_PIXEL},
    '{OP_START, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 1'b1, '{11'd0, 11'd0, 16'hFFFF, 1'b1, 1'b1}},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 1'b0, NO_PIXEL},
    '{OP_START, 2047, 2047, 2047, 2047, 2047, 2047, 16'h0000, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 1'b1,
      '{11'd2047, 11'd2047, 16'h0000, 1'b1, 1'b1}},
    '{OP_START, -2048, -2048, -1, -7, -300, -1, 16'h1234, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 1'b0, NO_PIXEL},
    '{OP_START, 5, -3, 6, -1, 7, -2, 16'h4321, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 1'b0, NO_PIXEL},
    '{OP_START, -2048, 0, 3, -2048, 2, 2, 16'hA5A5, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 12, 1'b0, NO_PIXEL},
    '{OP_START, 1, 1, 6, 1, 1, 6, 16'h0F0F, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 36, 1'b0, NO_PIXEL},
    '{OP_START, 1, 1, 1, 6, 6, 1, 16'hF0F0, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 20, 1'b0, NO_PIXEL},
    '{OP_START, 0, 0, 2, 2, 4, 4, 16'h5555, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 26, 1'b0, NO_PIXEL},
    '{OP_START, 0, 3, 7, 3, 3, 3, 16'hAAAA, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 8, 1'b0, NO_PIXEL},
    '{OP_START, 2040, 2040, 2047, 2047, 2047, 2040, 16'h8001, 1, 1'b0, NO_PIXEL},
    '{OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0000, 64, 1'b0, NO_PIXEL}
  };

  initial begin
    walking = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        send(dir_rows[i].op,
             pack_request(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].bx, dir_rows[i].by,
                          dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].color),
             dir_rows[i].typed, dir_rows[i].want);
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_gap_pct = 54;
          rx_stall_pct = 0;
        end
        2: begin
          tx_gap_pct = 0;
          rx_stall_pct = 54;
        end
        default: begin
          tx_gap_pct = 15;
          rx_stall_pct = 15;
        end
      endcase
      random_burst(PHASE_ITEMS);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tbe_pkg.sv
hw/rtl/tbe_setup.sv
hw/rtl/tbe_cover.sv
hw/rtl/triangle_bbox_edge_rasterizer_unit.sv
test/tb.sv
